// ===== hw/rtl/signed_int_to_radix_text_top_defines.svh =====
// Assertion macros for the signed integer to radix text block.
`ifndef SIGNED_INT_TO_RADIX_TEXT_TOP_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_TEXT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Plain property check, disabled while reset is high.
`define SITRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication check, disabled while reset is high.
`define SITRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SITRT_ASSERT(lbl, clk, rst, prop, msg)
`define SITRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sitrt_pkg.sv =====
// Shared types and constants of the signed integer to radix text block.
package sitrt_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int RADIX_W     = 5;
   localparam int NUM_DIGITS  = 32;
   localparam int DIGIT_IDX_W = 5;
   localparam int DIGIT_CNT_W = 6;
   localparam int SYM_IDX_W   = 4;
   localparam int BIT_CNT_W   = 5;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_IDX_W   = 2;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Register indexes (byte address / 8)
   typedef enum logic [REG_IDX_W-1:0] {
      REG_RADIX       = 2'd0,
      REG_SYMS_FIRST  = 2'd1,
      REG_SYMS_LAST   = 2'd2
   } reg_idx_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_CONV  = 5'b00100,
      ST_SIGN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // Controls from the sequencer to the digit unit
   typedef struct packed {
      logic clear;
      logic step;
   } conv_ctl_type;

endpackage

// ===== hw/rtl/sitrt_conv_unit.sv =====
// Shared digit-doubling unit: converts a bit stream, MSB first, into radix digits.
`include "signed_int_to_radix_text_top_defines.svh"

module sitrt_conv_unit import sitrt_pkg::*; #(
   parameter int DIGIT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  conv_ctl_type           ctl,
   input  logic [RADIX_W-1:0]     radix,
   input  logic                   bit_in,
   input  logic [DIGIT_IDX_W-1:0] rd_ptr,
   output logic [DIGIT_W-1:0]     rd_digit,
   output logic [DIGIT_CNT_W-1:0] num_digits
);

   logic [DIGIT_W-1:0]     digit_ff [NUM_DIGITS];
   logic [DIGIT_W-1:0]     digit_in [NUM_DIGITS];
   logic [DIGIT_CNT_W-1:0] nd_ff;
   logic [DIGIT_CNT_W-1:0] nd_in;

   logic [RADIX_W:0]      r_ext;
   logic [RADIX_W:0]      two_d [NUM_DIGITS];
   logic [NUM_DIGITS-1:0] gen;
   logic [NUM_DIGITS-1:0] prop;
   logic [NUM_DIGITS:0]   add_a;
   logic [NUM_DIGITS:0]   add_b;
   logic [NUM_DIGITS:0]   add_sum;
   logic [NUM_DIGITS:0]   carry;

   assign r_ext = {1'b0, radix};

   // Per digit: doubling overflows (generate) or overflows only with a carry in (propagate)
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         two_d[i] = {{(RADIX_W - DIGIT_W){1'b0}}, digit_ff[i], 1'b0};
         gen[i]   = (two_d[i] >= r_ext);
         prop[i]  = (two_d[i] == (r_ext - (RADIX_W+1)'(1)));
      end
   end

   // Digit carries resolved by one wide add
   assign add_a   = {1'b0, gen | prop};
   assign add_b   = {1'b0, gen};
   assign add_sum = add_a + add_b + {{NUM_DIGITS{1'b0}}, bit_in};

   always_comb begin
      carry[0] = bit_in;
      for (int i = 1; i <= NUM_DIGITS; i++) begin
         carry[i] = add_sum[i] ^ add_a[i] ^ add_b[i];
      end
   end

   // New digit = 2d + carry in, less radix on carry out
   always_comb begin
      logic [RADIX_W:0] tmp;
      tmp = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         tmp = two_d[i] + {{RADIX_W{1'b0}}, carry[i]} - (carry[i+1] ? r_ext : '0);
         if (ctl.clear) begin
            digit_in[i] = '0;
         end else if (ctl.step) begin
            digit_in[i] = tmp[DIGIT_W-1:0];
         end else begin
            digit_in[i] = digit_ff[i];
         end
      end
   end

   // Significant digit count grows when a carry reaches the first zero position
   always_comb begin
      nd_in = nd_ff;
      if (ctl.clear) begin
         nd_in = DIGIT_CNT_W'(1);
      end else if (ctl.step && carry[nd_ff]) begin
         nd_in = nd_ff + DIGIT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff <= DIGIT_CNT_W'(1);
      end else begin
         nd_ff <= nd_in;
      end
   end

   assign rd_digit   = digit_ff[rd_ptr];
   assign num_digits = nd_ff;

   `SITRT_ASSERT_IMPL(a_no_top_overflow, clock, reset, ctl.step, !carry[NUM_DIGITS],
      "carry out of top digit")
   `SITRT_ASSERT(a_nd_range, clock, reset,
      (nd_ff != '0) && (nd_ff <= DIGIT_CNT_W'(NUM_DIGITS)), "digit count out of range")
   `SITRT_ASSERT(a_ctl_excl, clock, reset, !(ctl.clear && ctl.step), "clear and step together")

endmodule

// ===== hw/rtl/signed_int_to_radix_text_top.sv =====
// Signed 32-bit integer to radix text converter with APB-style configuration.
// An accepted request passes CHECK, 32 conversion steps and SIGN before its first digit byte;
// a minus sign is loaded in SIGN, and an invalid alphabet gives its error byte in CHECK.
// A new request is taken only in IDLE, once the last byte is loaded. The digits (up to 32) come
// from 32 bit-serial passes through the shared digit adder; one byte per cycle out unless stalled.
// Reset (synchronous, active high) clears the sequencer, the output valid and the CSRs.
`include "signed_int_to_radix_text_top_defines.svh"

module signed_int_to_radix_text_top import sitrt_pkg::*; #(
   parameter int MAX_RADIX = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_last,
   output logic                    rsp_base_error,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);

   // Configuration registers
   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] syms_first_ff;
   logic [CSR_DATA_W-1:0] syms_last_ff;
   reg_idx_type           reg_idx;
   logic                  csr_wr;

   // Sequencer
   state_type              state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_IDX_W-1:0] ptr_ff, ptr_in;
   conv_ctl_type           conv_ctl;

   // Output register
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;
   logic              can_load;

   // Digit unit and symbol lookup
   logic [DIGIT_W-1:0]          rd_digit;
   logic [DIGIT_CNT_W-1:0]      num_digits;
   logic [2*CSR_DATA_W-1:0]     sym_all;
   logic [CHAR_W-1:0]           sym_tab [MAX_RADIX];
   logic [SYM_IDX_W-1:0]        sym_idx;
   logic [CHAR_W-1:0]           digit_char;
   logic                        alpha_bad;
   logic [VALUE_W-1:0]          raw;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= '0;
         syms_first_ff <= '0;
         syms_last_ff  <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_RADIX:      radix_ff      <= csr_pwdata[RADIX_W-1:0];
            REG_SYMS_FIRST: syms_first_ff <= csr_pwdata;
            REG_SYMS_LAST:  syms_last_ff  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Read data
   always_comb begin
      case (reg_idx)
         REG_RADIX:      csr_prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         REG_SYMS_FIRST: csr_prdata = syms_first_ff;
         REG_SYMS_LAST:  csr_prdata = syms_last_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- alphabet check ----------------
   assign sym_all = {syms_last_ff, syms_first_ff};

   always_comb begin
      for (int i = 0; i < MAX_RADIX; i++) begin
         sym_tab[i] = sym_all[i*CHAR_W +: CHAR_W];
      end
   end

   // Bad if radix out of range, a sign character is in use, or two symbols in use match
   always_comb begin
      alpha_bad = (radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_RADIX));
      for (int i = 0; i < MAX_RADIX; i++) begin
         if (RADIX_W'(i) < radix_ff) begin
            if ((sym_tab[i] == CHAR_PLUS) || (sym_tab[i] == CHAR_MINUS)) begin
               alpha_bad = 1'b1;
            end
         end
         for (int j = i + 1; j < MAX_RADIX; j++) begin
            if ((RADIX_W'(j) < radix_ff) && (sym_tab[i] == sym_tab[j])) begin
               alpha_bad = 1'b1;
            end
         end
      end
   end

   // ---------------- digit unit ----------------
   sitrt_conv_unit #(
      .DIGIT_W (DIGIT_W)
   ) u_conv (
      .clock      (clock),
      .reset      (reset),
      .ctl        (conv_ctl),
      .radix      (radix_ff),
      .bit_in     (mag_ff[VALUE_W-1]),
      .rd_ptr     (ptr_ff),
      .rd_digit   (rd_digit),
      .num_digits (num_digits)
   );

   assign sym_idx    = SYM_IDX_W'(rd_digit);
   assign digit_char = sym_all[sym_idx*CHAR_W +: CHAR_W];

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign can_load  = !out_valid_ff || rsp_ready;
   assign raw       = req_value;

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      bit_cnt_in    = bit_cnt_ff;
      ptr_in        = ptr_ff;
      conv_ctl      = '0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;

      case (state_ff)
         ST_IDLE: begin
            // Take the request and form the magnitude
            if (req_valid) begin
               neg_in   = raw[VALUE_W-1];
               mag_in   = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (alpha_bad) begin
               // Single error byte
               if (can_load) begin
                  out_valid_in = 1'b1;
                  out_char_in  = '0;
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               conv_ctl.clear = 1'b1;
               bit_cnt_in     = '0;
               state_in       = ST_CONV;
            end
         end
         ST_CONV: begin
            // One magnitude bit per cycle, MSB first
            conv_ctl.step = 1'b1;
            mag_in        = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in    = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W-1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            ptr_in = DIGIT_IDX_W'(num_digits - DIGIT_CNT_W'(1));
            if (!neg_ff) begin
               state_in = ST_EMIT;
            end else if (can_load) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               out_err_in   = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Most significant digit first
            if (can_load) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char;
               out_last_in  = (ptr_ff == '0);
               out_err_in   = 1'b0;
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - DIGIT_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      ptr_ff      <= ptr_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_character  = out_char_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_base_error = out_err_ff;

   `SITRT_ASSERT_IMPL(a_err_form, clock, reset, out_valid_ff && out_err_ff,
      out_last_ff && (out_char_ff == '0), "error byte not last or not zero")
   `SITRT_ASSERT_IMPL(a_pending_busy, clock, reset, out_valid_ff && !out_last_ff,
      state_ff != ST_IDLE, "idle with text unfinished")
   `SITRT_ASSERT_IMPL(a_sign_not_last, clock, reset, (state_ff == ST_SIGN) && neg_ff && can_load,
      !out_last_in, "minus sign marked last")

endmodule
